/* src/assert_macros.svh */
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition never seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/mpa_pkg.sv */
`default_nettype none

package mpa_pkg;

  // sizes fixed by the field definitions
  localparam int ValueW    = 32;
  localparam int MaxImage  = 64;
  localparam int IdxW      = 12;
  localparam int ImgW      = 7;
  localparam int PoolW     = 4;
  localparam int PoolMax   = 8;
  localparam int PoolCntW  = 3;

  // configuration port
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;

  localparam logic [CfgIdxW-1:0] RegImageSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPoolSize  = 2'd1;

  localparam logic [ImgW-1:0]  ImageReset = 7'd28;
  localparam logic [PoolW-1:0] PoolReset  = 4'd2;

  // result queue
  localparam int ResDepth = 4;

endpackage

`default_nettype wire

/* src/mpa_in_if.sv */
`default_nettype none

interface mpa_in_if #(
  parameter int VALUE_WIDTH = mpa_pkg::ValueW
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* src/mpa_out_if.sv */
`default_nettype none

interface mpa_out_if #(
  parameter int VALUE_WIDTH = mpa_pkg::ValueW
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] pooled_value;
  logic [mpa_pkg::IdxW-1:0]      source_index;
  logic                          frame_last;

  modport source (output valid, output pooled_value, output source_index,
                  output frame_last, input ready);
  modport sink   (input valid, input pooled_value, input source_index,
                  input frame_last, output ready);
endinterface

`default_nettype wire

/* src/mpa_cfg_if.sv */
`default_nettype none

interface mpa_cfg_if ();
  logic                         valid;
  logic                         ready;
  logic [mpa_pkg::CfgIdxW-1:0]  index;
  logic [mpa_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/mpa_res_fifo.sv */
`default_nettype none

module mpa_res_fifo #(
  parameter int Width = mpa_pkg::ValueW + mpa_pkg::IdxW + 1,
  parameter int Depth = mpa_pkg::ResDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [Width-1:0]           push_data_i,
  input  wire logic                       pop_i,
  output logic                            valid_o,
  output logic [Width-1:0]                data_o,
  output logic [$clog2(Depth+1)-1:0]      count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* src/max_pool_with_argmax_top.sv */
// results pass the update stage register, then the result queue, before they are offered
// throughput: one sample per cycle while input ready is high, with band write forwarding
// results queue in a four-entry buffer, so input keeps flowing while a result waits
// reset: counters clear, image_size 28 and pool_size 2; band memory is not cleared
// after reset and after each register write a setup pass
// recomputes window counters from the raster position, input ready low meanwhile
`default_nettype none

module max_pool_with_argmax_top #(
  parameter int MAX_IMAGE   = mpa_pkg::MaxImage,
  parameter int VALUE_WIDTH = mpa_pkg::ValueW
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpa_cfg_if.sink   cfg_i,
  mpa_in_if.sink    in_i,
  mpa_out_if.source out_o
);

  `include "assert_macros.svh"

  localparam int PW   = $clog2(MAX_IMAGE);          // position / window number
  localparam int NW   = $clog2(MAX_IMAGE + 1);      // image side
  localparam int XW   = PW + NW;                    // full raster index
  localparam int IW   = mpa_pkg::IdxW;
  localparam int CW   = mpa_pkg::PoolCntW;
  localparam int QW   = mpa_pkg::PoolW;
  localparam int WW   = VALUE_WIDTH + IW;           // band memory word
  localparam int RW   = WW + 1;                     // queued result
  localparam int DEP  = mpa_pkg::ResDepth;
  localparam int CntW = $clog2(DEP + 1);

  // configuration registers, as written
  logic [mpa_pkg::ImgW-1:0] img_q;
  logic [QW-1:0]            pool_q;

  // effective sizes, latched by the setup pass
  logic [NW-1:0] n_q;
  logic [QW-1:0] p_q;
  logic [NW-1:0] win_q;
  logic [NW-1:0] n_new;
  logic [QW-1:0] p_new;

  // raster position and derived window counters
  logic [PW-1:0] r_q, c_q;
  logic [CW-1:0] cw_q, rw_q;
  logic [PW-1:0] j_q, wr_q;

  // setup pass
  logic          resync_q, init_q;
  logic [NW-1:0] k_q;
  logic [NW-1:0] acc_q;
  logic [NW+3:0] acc_sum;
  logic          win_fits, col_walk, row_walk;

  // counter steps
  logic [CW-1:0] cw_inc, rw_inc;
  logic [PW-1:0] j_inc, wr_inc;
  logic          col_end, row_end;

  // sample stage
  logic          accept;
  logic          s0_cover, s0_first, s0_last, s0_flast;
  logic [XW-1:0] s0_idx_full;

  // update stage
  logic                          s1_valid_q;
  logic                          s1_cover_q, s1_first_q, s1_last_q, s1_flast_q;
  logic signed [VALUE_WIDTH-1:0] s1_v_q;
  logic [IW-1:0]                 s1_idx_q;
  logic [PW-1:0]                 s1_j_q;

  // band memory with one-deep forwarding of the last write
  logic [WW-1:0]                 band_q [MAX_IMAGE];
  logic [WW-1:0]                 rd_q;
  logic                          fwd_valid_q;
  logic [PW-1:0]                 fwd_addr_q;
  logic [WW-1:0]                 fwd_data_q;
  logic [WW-1:0]                 old_word, new_word;
  logic signed [VALUE_WIDTH-1:0] old_val;
  logic                          band_we, res_push;

  // result queue
  logic [RW-1:0]   res_head;
  logic [CntW-1:0] res_count;
  logic            res_valid;

  // ---------------------------------------------------------------------------
  // configuration: always ready, any write restarts the setup pass
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q  <= mpa_pkg::ImageReset;
      pool_q <= mpa_pkg::PoolReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mpa_pkg::RegImageSize: img_q  <= cfg_i.data;
        mpa_pkg::RegPoolSize:  pool_q <= QW'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // clamp sizes to their legal ranges
  always_comb begin
    if (int'(img_q) < 2) begin
      n_new = NW'(2);
    end else if (int'(img_q) > MAX_IMAGE) begin
      n_new = NW'(MAX_IMAGE);
    end else begin
      n_new = NW'(img_q);
    end
    if (pool_q == '0) begin
      p_new = QW'(1);
    end else if (int'(pool_q) > mpa_pkg::PoolMax) begin
      p_new = QW'(mpa_pkg::PoolMax);
    end else begin
      p_new = pool_q;
    end
  end

  // ---------------------------------------------------------------------------
  // counter steps shared by the stream and the setup walk
  // ---------------------------------------------------------------------------
  always_comb begin
    if ({1'b0, cw_q} == p_q - 1'b1) begin
      cw_inc = '0;
      j_inc  = j_q + 1'b1;
    end else begin
      cw_inc = cw_q + 1'b1;
      j_inc  = j_q;
    end
    if ({1'b0, rw_q} == p_q - 1'b1) begin
      rw_inc = '0;
      wr_inc = wr_q + 1'b1;
    end else begin
      rw_inc = rw_q + 1'b1;
      wr_inc = wr_q;
    end
  end

  assign col_end = (NW'(c_q) == n_q - 1'b1);
  assign row_end = (NW'(r_q) == n_q - 1'b1);

  // setup walk: k steps up to the column, the row and the window count at once
  assign acc_sum  = (NW + 4)'(acc_q) + (NW + 4)'(p_q);
  assign win_fits = (acc_sum <= (NW + 4)'(n_q));
  assign col_walk = (k_q < NW'(c_q));
  assign row_walk = (k_q < NW'(r_q));

  // ---------------------------------------------------------------------------
  // sample stage: classify the position, read the band entry
  // ---------------------------------------------------------------------------
  assign in_i.ready = !resync_q && ((CntW + 1)'(res_count) + (CntW + 1)'(s1_valid_q)
                                    < (CntW + 1)'(DEP));
  assign accept     = in_i.valid && in_i.ready;

  assign s0_cover    = (NW'(wr_q) < win_q) && (NW'(j_q) < win_q);
  assign s0_first    = (rw_q == '0) && (cw_q == '0);
  assign s0_last     = ({1'b0, rw_q} == p_q - 1'b1) && ({1'b0, cw_q} == p_q - 1'b1);
  assign s0_flast    = (NW'(wr_q) == win_q - 1'b1) && (NW'(j_q) == win_q - 1'b1);
  assign s0_idx_full = XW'(r_q) * XW'(n_q) + XW'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resync_q <= 1'b1;
      init_q   <= 1'b1;
      n_q      <= '0;
      p_q      <= '0;
      win_q    <= '0;
      k_q      <= '0;
      acc_q    <= '0;
      r_q      <= '0;
      c_q      <= '0;
      cw_q     <= '0;
      rw_q     <= '0;
      j_q      <= '0;
      wr_q     <= '0;
    end else if (cfg_i.valid) begin
      resync_q <= 1'b1;
      init_q   <= 1'b1;
    end else if (init_q) begin
      // latch sizes, restart the frame when the position fell outside the image
      init_q <= 1'b0;
      n_q    <= n_new;
      p_q    <= p_new;
      win_q  <= '0;
      k_q    <= '0;
      acc_q  <= '0;
      cw_q   <= '0;
      rw_q   <= '0;
      j_q    <= '0;
      wr_q   <= '0;
      if (NW'(r_q) >= n_new || NW'(c_q) >= n_new) begin
        r_q <= '0;
        c_q <= '0;
      end
    end else if (resync_q) begin
      if (col_walk) begin
        cw_q <= cw_inc;
        j_q  <= j_inc;
      end
      if (row_walk) begin
        rw_q <= rw_inc;
        wr_q <= wr_inc;
      end
      if (win_fits) begin
        acc_q <= NW'(acc_sum);
        win_q <= win_q + 1'b1;
      end
      k_q <= k_q + 1'b1;
      if (!col_walk && !row_walk && !win_fits) begin
        resync_q <= 1'b0;
      end
    end else if (accept) begin
      if (col_end) begin
        c_q  <= '0;
        cw_q <= '0;
        j_q  <= '0;
        if (row_end) begin
          r_q  <= '0;
          rw_q <= '0;
          wr_q <= '0;
        end else begin
          r_q  <= r_q + 1'b1;
          rw_q <= rw_inc;
          wr_q <= wr_inc;
        end
      end else begin
        c_q  <= c_q + 1'b1;
        cw_q <= cw_inc;
        j_q  <= j_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // update stage: compare against the running maximum and write back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cover_q <= s0_cover;
      s1_first_q <= s0_first;
      s1_last_q  <= s0_last;
      s1_flast_q <= s0_flast;
      s1_v_q     <= in_i.sample;
      s1_idx_q   <= IW'(s0_idx_full);
      s1_j_q     <= j_q;
    end
  end

  // previous write lands on the same edge as this read, so take it from the bypass
  assign old_word = (fwd_valid_q && fwd_addr_q == s1_j_q) ? fwd_data_q : rd_q;
  assign old_val  = signed'(old_word[VALUE_WIDTH-1:0]);
  assign new_word = (s1_first_q || s1_v_q > old_val) ? {s1_idx_q, s1_v_q} : old_word;
  assign band_we  = s1_valid_q && s1_cover_q;
  assign res_push = band_we && s1_last_q;

  always_ff @(posedge clk_i) begin
    rd_q <= band_q[j_q];
    if (band_we) begin
      band_q[s1_j_q] <= new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= band_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (band_we) begin
      fwd_addr_q <= s1_j_q;
      fwd_data_q <= new_word;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue and output request
  // ---------------------------------------------------------------------------
  mpa_res_fifo #(
    .Width (RW),
    .Depth (DEP)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i ({s1_flast_q, new_word}),
    .pop_i       (out_o.ready),
    .valid_o     (res_valid),
    .data_o      (res_head),
    .count_o     (res_count)
  );

  assign out_o.valid        = res_valid;
  assign out_o.pooled_value = signed'(res_head[VALUE_WIDTH-1:0]);
  assign out_o.source_index = res_head[WW-1:VALUE_WIDTH];
  assign out_o.frame_last   = res_head[RW-1];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `ASSERT_NEVER(a_queue_overflow, res_push && res_count == CntW'(DEP),
                "result pushed into a full queue")
  `ASSERT_NEVER(a_band_addr, band_we && NW'(s1_j_q) >= win_q,
                "band write outside the covered windows")
  `ASSERT_CLK(a_pool_count, !init_q |-> ({1'b0, cw_q} < p_q && {1'b0, rw_q} < p_q),
              "window offset counter beyond pool size")
  `ASSERT_CLK(a_row_start, !resync_q && c_q == '0 |-> (cw_q == '0 && j_q == '0),
              "column counters out of step with position")

endmodule

`default_nettype wire
